@@ rtl/assert_macros.svh @@
// Assertion macros shared by the step limiter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and arst_n to exist in the enclosing module.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define ASSERT_IMPLIES(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

@@ rtl/vtsl_pkg.sv @@
// Shared types and constants for the vector target step limiter.
package vtsl_pkg;

	localparam int NUM_SLOTS  = 4;
	localparam int SLOT_IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int SLOT_FW    = 2;
	localparam int POS_W      = 20;
	localparam int DELTA_W    = POS_W + 1;
	localparam int MAG_W      = POS_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int STEP_W     = 17;
	localparam int PROD_W     = MAG_W + STEP_W;
	localparam int QUO_W      = STEP_W;
	localparam int DIV_CNT_W  = $clog2(QUO_W);
	localparam int SQRT_STEPS = SUM_W / 2;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		logic [SLOT_FW-1:0] slot;
		pos_t               target_x;
		pos_t               target_y;
		pos_t               target_z;
	} in_t;

	typedef struct packed {
		pos_t limited_x;
		pos_t limited_y;
		pos_t limited_z;
		logic was_clipped;
	} out_t;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
	} pos_vec_t;

	typedef struct packed {
		logic delta_en;
		logic square_en;
		logic div_load;
		logic div_step;
	} lane_ctrl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SQUARE,
		ST_SUM,
		ST_SQRT,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

@@ rtl/vtsl_lane.sv @@
// One axis lane: delta, magnitude, square, and the bit-serial scale divide.
module vtsl_lane (
	input  logic                         clk,
	input  vtsl_pkg::lane_ctrl_t         ctrl,
	input  vtsl_pkg::pos_t               target,
	input  vtsl_pkg::pos_t               last,
	input  logic [vtsl_pkg::STEP_W-1:0]  max_step,
	input  logic [vtsl_pkg::ROOT_W-1:0]  distance,
	output logic [vtsl_pkg::SQ_W-1:0]    sq,
	output vtsl_pkg::pos_t               res
);
	import vtsl_pkg::*;

	logic signed [DELTA_W-1:0] delta;
	logic [DELTA_W-1:0]        delta_abs;
	logic                      neg_q;
	logic [MAG_W-1:0]          mag_q;
	logic [SQ_W-1:0]           sq_q;
	logic [PROD_W-1:0]         prod_q;
	logic [ROOT_W-1:0]         rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic [ROOT_W:0]           trial;
	logic [ROOT_W:0]           dist_ext;
	logic                      trial_ge;
	logic [POS_W-1:0]          q_ext;
	logic [POS_W-1:0]          q_sgn;

	assign delta     = DELTA_W'(target) - DELTA_W'(last);
	assign delta_abs = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);

	// The quotient shifts in from the bottom while the low dividend bits leave at the top.
	assign trial    = {rem_q, quo_q[QUO_W-1]};
	assign dist_ext = {1'b0, distance};
	assign trial_ge = (trial >= dist_ext);

	always_ff @(posedge clk) begin
		if (ctrl.delta_en) begin
			neg_q <= delta[DELTA_W-1];
			mag_q <= delta_abs[MAG_W-1:0];
		end
		if (ctrl.square_en) begin
			sq_q   <= SQ_W'(mag_q) * SQ_W'(mag_q);
			prod_q <= PROD_W'(mag_q) * PROD_W'(max_step);
		end
		if (ctrl.div_load) begin
			// The quotient does not exceed max_step, so the upper bits are already below the distance.
			rem_q <= ROOT_W'(prod_q[PROD_W-1:QUO_W]);
			quo_q <= prod_q[QUO_W-1:0];
		end else if (ctrl.div_step) begin
			rem_q <= trial_ge ? ROOT_W'(trial - dist_ext) : ROOT_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
	end

	assign q_ext = POS_W'(quo_q);
	assign q_sgn = neg_q ? (~q_ext + POS_W'(1)) : q_ext;
	assign sq    = sq_q;
	assign res   = last + $signed(q_sgn);

endmodule

@@ rtl/vtsl_isqrt.sv @@
// Floor integer square root, one result bit per cycle.
`include "assert_macros.svh"

module vtsl_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vtsl_pkg::SUM_W-1:0]  radicand,
	output logic                        done,
	output logic [vtsl_pkg::ROOT_W-1:0] root
);
	import vtsl_pkg::*;

	logic [SUM_W-1:0]      rad_q;
	logic [ROOT_W:0]       rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [SQRT_CNT_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [ROOT_W+2:0]     r2;
	logic [ROOT_W+2:0]     trial;
	logic                  take;

	assign r2    = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial = (ROOT_W+3)'({root_q, 2'b01});
	assign take  = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + SQRT_CNT_W'(1);
				if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= take ? (ROOT_W+1)'(r2 - trial) : (ROOT_W+1)'(r2);
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

	`ASSERT_CLK(a_start_busy, start |=> busy_q, "square root did not start after a start pulse")
	`ASSERT_IMPLIES(a_done_after_busy, done_q, $past(busy_q), "square root done without a run")

endmodule

@@ rtl/vector_target_step_limiter.sv @@
// Top level: slot store, sequencer, three axis lanes, square root and result merge.
// A new item is taken only from the idle state, once the previous one has gone through
// the delta, square and sum states, the 21-step square root and the 17-step divide that
// all three lanes run together, and has been loaded into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset clears max_step, every slot valid mark and the sequencer; stored targets are not cleared.
`include "assert_macros.svh"

module vector_target_step_limiter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  vtsl_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output vtsl_pkg::out_t              out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [vtsl_pkg::STEP_W-1:0] cfg_data
);
	import vtsl_pkg::*;

	state_t                state_q, state_d;
	logic [STEP_W-1:0]     max_step_q;
	in_t                   in_q;
	pos_vec_t              rd_q;
	pos_vec_t              mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  slot_vld_q;
	logic                  en_q, vld_q, clip_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;
	out_t                  out_q;
	logic                  out_valid_q;
	lane_ctrl_t            lane_ctrl;
	logic                  sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]     distance;
	logic [SQ_W-1:0]       sq_x, sq_y, sq_z;
	pos_t                  res_x, res_y, res_z;
	logic                  load_out;
	logic                  accept;
	logic                  in_range;
	logic [SLOT_IW-1:0]    rd_idx, wr_idx;
	out_t                  merged;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;
	assign in_range  = (32'(in_data.slot) < NUM_SLOTS);
	assign rd_idx    = SLOT_IW'(in_data.slot);
	assign wr_idx    = SLOT_IW'(in_q.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		lane_ctrl  = '0;
		sqrt_start = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: begin
				lane_ctrl.delta_en = 1'b1;
				state_d            = ST_SQUARE;
			end
			ST_SQUARE: begin
				lane_ctrl.square_en = 1'b1;
				state_d             = ST_SUM;
			end
			ST_SUM: begin
				sqrt_start = 1'b1;
				state_d    = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				lane_ctrl.div_load = 1'b1;
				state_d            = ST_DIV;
			end
			ST_DIV: begin
				lane_ctrl.div_step = 1'b1;
				if (div_cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q  <= '0;
			slot_vld_q  <= '0;
			en_q        <= 1'b0;
			vld_q       <= 1'b0;
			clip_q      <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_step_q <= cfg_data;
			end
			if (accept) begin
				en_q  <= (max_step_q != '0) && in_range;
				vld_q <= in_range && slot_vld_q[rd_idx];
			end
			if (lane_ctrl.div_load) begin
				clip_q    <= en_q && vld_q && (distance > ROOT_W'(max_step_q));
				div_cnt_q <= '0;
			end else if (lane_ctrl.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (load_out && en_q) begin
				slot_vld_q[wr_idx] <= 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Stored targets have no reset; an entry is only used once its valid mark is set.
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
			rd_q <= mem[rd_idx];
		end
		if (load_out && en_q) begin
			mem[wr_idx] <= '{x: merged.limited_x, y: merged.limited_y, z: merged.limited_z};
		end
		if (load_out) begin
			out_q <= merged;
		end
	end

	vtsl_lane u_lane_x (
		.clk      (clk),
		.ctrl     (lane_ctrl),
		.target   (in_q.target_x),
		.last     (rd_q.x),
		.max_step (max_step_q),
		.distance (distance),
		.sq       (sq_x),
		.res      (res_x)
	);

	vtsl_lane u_lane_y (
		.clk      (clk),
		.ctrl     (lane_ctrl),
		.target   (in_q.target_y),
		.last     (rd_q.y),
		.max_step (max_step_q),
		.distance (distance),
		.sq       (sq_y),
		.res      (res_y)
	);

	vtsl_lane u_lane_z (
		.clk      (clk),
		.ctrl     (lane_ctrl),
		.target   (in_q.target_z),
		.last     (rd_q.z),
		.max_step (max_step_q),
		.distance (distance),
		.sq       (sq_z),
		.res      (res_z)
	);

	vtsl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z)),
		.done     (sqrt_done),
		.root     (distance)
	);

	// Merge: the lanes' scaled positions are used only when the move was clipped.
	always_comb begin
		merged.limited_x   = clip_q ? res_x : in_q.target_x;
		merged.limited_y   = clip_q ? res_y : in_q.target_y;
		merged.limited_z   = clip_q ? res_z : in_q.target_z;
		merged.was_clipped = clip_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_CLK(a_accept_starts, (in_valid && in_ready) |=> (state_q == ST_DELTA),
		"accepted item did not start")
	`ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> ($past(state_q) == ST_DONE),
		"result appeared outside the done state")
	`ASSERT_IMPLIES(a_clip_needs_dist, (state_q == ST_DIV) && clip_q,
		distance > ROOT_W'(max_step_q), "clipped without exceeding max_step")

endmodule

@@ bench/tb_vector_target_step_limiter.sv @@
// Self-checking testbench for the vector target step limiter.
module tb_vector_target_step_limiter;
	import vtsl_pkg::*;

	localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
	localparam int POS_MIN = -(1 << (POS_W - 1));
	localparam int HALF_PHASE = 102;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_t               in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [STEP_W-1:0] cfg_data = '0;

	// Bench copy of the block state, updated as items and writes are accepted.
	longint step_limit = 0;
	longint held_x[NUM_SLOTS];
	longint held_y[NUM_SLOTS];
	longint held_z[NUM_SLOTS];
	bit     held_ok[NUM_SLOTS];

	in_t  target_q[$];
	out_t limited_q[$];
	in_t  aim[NUM_SLOTS] = '{default: '0};
	out_t due;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   errors = 0;

	vector_target_step_limiter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint floor_sqrt(longint v);
		longint r;
		longint t;
		int     b;
		r = 0;
		for (b = 22; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic longint scale_toward(longint d, longint distance);
		longint q;
		q = ((d < 0) ? -d : d) * step_limit / distance;
		return (d < 0) ? -q : q;
	endfunction

	function automatic out_t apply_step_limit(in_t item);
		longint tx;
		longint ty;
		longint tz;
		longint dx;
		longint dy;
		longint dz;
		longint distance;
		int     s;
		out_t   r;
		tx = item.target_x;
		ty = item.target_y;
		tz = item.target_z;
		s = item.slot;
		r.was_clipped = 1'b0;
		if (step_limit != 0 && s < NUM_SLOTS) begin
			if (held_ok[s]) begin
				dx = tx - held_x[s];
				dy = ty - held_y[s];
				dz = tz - held_z[s];
				distance = floor_sqrt(dx * dx + dy * dy + dz * dz);
				if (distance > step_limit) begin
					tx = held_x[s] + scale_toward(dx, distance);
					ty = held_y[s] + scale_toward(dy, distance);
					tz = held_z[s] + scale_toward(dz, distance);
					r.was_clipped = 1'b1;
				end
			end
			held_x[s] = tx;
			held_y[s] = ty;
			held_z[s] = tz;
			held_ok[s] = 1'b1;
		end
		r.limited_x = tx[POS_W-1:0];
		r.limited_y = ty[POS_W-1:0];
		r.limited_z = tz[POS_W-1:0];
		return r;
	endfunction

	function automatic bit drained();
		return target_q.size() == 0 && !in_valid && limited_q.size() == 0;
	endfunction

	// Random offset from a base position, clamped to the position range.
	function automatic pos_t nudge(pos_t base, int span);
		int v;
		v = int'(base) + int'($urandom_range(2 * span)) - span;
		if (v > POS_MAX)
			v = POS_MAX;
		if (v < POS_MIN)
			v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	task automatic queue_target(int slot, int x, int y, int z);
		in_t t;
		t.slot = slot[SLOT_FW-1:0];
		t.target_x = x[POS_W-1:0];
		t.target_y = y[POS_W-1:0];
		t.target_z = z[POS_W-1:0];
		aim[t.slot] = t;
		target_q.push_back(t);
	endtask

	// Mostly moves around the last request of the slot, sized against the
	// current limit so that both clipped and unclipped moves are common.
	task automatic queue_random_targets(int count);
		in_t t;
		int  span;
		int  pick;
		repeat (count) begin
			t.slot = SLOT_FW'($urandom_range((1 << SLOT_FW) - 1));
			pick = $urandom_range(99);
			if (pick < 25) begin
				t.target_x = pos_t'($urandom());
				t.target_y = pos_t'($urandom());
				t.target_z = pos_t'($urandom());
			end else if (pick < 30) begin
				t = aim[t.slot];
			end else begin
				if (step_limit == 0)
					span = $urandom_range(4000, 1);
				else
					span = int'(step_limit) * int'($urandom_range(8, 1)) / 4 + 1;
				t.target_x = nudge(aim[t.slot].target_x, span);
				t.target_y = nudge(aim[t.slot].target_y, span);
				t.target_z = nudge(aim[t.slot].target_z, span);
			end
			aim[t.slot] = t;
			target_q.push_back(t);
		end
	endtask

	// Checked at the falling edge, once the rising-edge updates have settled.
	task automatic wait_drained();
		do @(negedge clk); while (!drained());
	endtask

	task automatic write_max_step(int value);
		wait_drained();
		@(posedge clk);
		cfg_data  <= value[STEP_W-1:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		step_limit = value[STEP_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				limited_q.push_back(apply_step_limit(in_data));
			if (!in_valid || in_ready) begin
				if (target_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data  <= target_q.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (limited_q.size() == 0) begin
					$error("result with none expected: %p", out_data);
					errors++;
				end else begin
					due = limited_q.pop_front();
					if (out_data.limited_x !== due.limited_x) begin
						$error("limited_x: expected %0d, got %0d", due.limited_x,
							out_data.limited_x);
						errors++;
					end
					if (out_data.limited_y !== due.limited_y) begin
						$error("limited_y: expected %0d, got %0d", due.limited_y,
							out_data.limited_y);
						errors++;
					end
					if (out_data.limited_z !== due.limited_z) begin
						$error("limited_z: expected %0d, got %0d", due.limited_z,
							out_data.limited_z);
						errors++;
					end
					if (out_data.was_clipped !== due.was_clipped) begin
						$error("was_clipped: expected %0d, got %0d", due.was_clipped,
							out_data.was_clipped);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int step_plan[8] = '{65536, 1, 0, -1, 300, 65536, -1, -2};
		int send_plan[8] = '{0, 82, 0, 21, 0, 82, 0, 21};
		int recv_plan[8] = '{0, 0, 82, 21, 0, 0, 82, 21};
		int phase;
		int step;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Limiting is off after reset, so extremes pass untouched and nothing is stored.
		queue_target(0, POS_MAX, POS_MIN, 0);
		queue_target(3, POS_MIN, POS_MAX, -1);

		write_max_step(65536);
		queue_target(0, 0, 0, 0);
		queue_target(0, POS_MAX, POS_MAX, POS_MAX);
		queue_target(0, POS_MIN, POS_MIN, POS_MIN);
		queue_target(1, 1000, 2000, 3000);
		// A move of exactly the limit is kept; one more unit gets clipped.
		queue_target(1, 66536, 2000, 3000);
		queue_target(1, 132073, 2000, 3000);
		queue_target(2, POS_MIN, POS_MAX, POS_MIN);
		queue_target(2, POS_MAX, POS_MIN, POS_MAX);

		write_max_step(1);
		queue_target(1, 132072, 2000, 3000);
		queue_target(1, 132073, 2001, 3000);
		queue_target(1, 132075, 2001, 3000);
		// The scaled move truncates to zero here, yet the item still counts as clipped.
		queue_target(1, 132071, 1998, 2997);

		write_max_step(0);
		queue_target(1, POS_MAX, POS_MAX, POS_MAX);
		queue_target(2, 0, 0, 0);

		for (phase = 0; phase < 8; phase++) begin
			if (step_plan[phase] == -1)
				step = $urandom_range(65535, 2);
			else if (step_plan[phase] == -2)
				step = $urandom_range(200, 2);
			else
				step = step_plan[phase];
			write_max_step(step);
			send_idle_pct = send_plan[phase];
			recv_stall_pct = recv_plan[phase];
			queue_random_targets(HALF_PHASE);
			// Hold the sender back until the block has emptied out.
			wait_drained();
			queue_random_targets(HALF_PHASE);
		end

		wait_drained();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
